/* rtl/mffp_pkg.sv */
// Shared types and constants for the motor feedback frame parser.
// Holds parse phase codes, register indexes and payload types.
// No dependencies; compile this file first.
package mffp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  phase_t;
  typedef logic [2:0]  count_t;

  localparam phase_t PH_HEADER = 3'd0;
  localparam phase_t PH_ADDR   = 3'd1;
  localparam phase_t PH_TYPE   = 3'd2;
  localparam phase_t PH_DATA   = 3'd3;
  localparam phase_t PH_CHECK  = 3'd4;
  localparam phase_t PH_TAIL   = 3'd5;

  localparam count_t DATA_BYTES = 3'd4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_HEADER   = 3'd0;
  localparam logic [2:0] REG_TAIL     = 3'd1;
  localparam logic [2:0] REG_ADDR0    = 3'd2;
  localparam logic [2:0] REG_ADDR1    = 3'd3;
  localparam logic [2:0] REG_MAX_TYPE = 3'd4;

endpackage

/* rtl/mffp_if.sv */
// Valid/ready channel interfaces for the motor feedback frame parser.
// One interface for received bytes and one for parsed frame results.
// Depends on mffp_pkg for the payload types.
interface mffp_in_if;
  logic           valid;
  logic           ready;
  mffp_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mffp_out_if;
  logic            valid;
  logic            ready;
  logic            motor_sel;
  mffp_pkg::byte_t feedback_type;
  mffp_pkg::word_t raw_value;

  modport source (output valid, output motor_sel, output feedback_type, output raw_value,
                  input ready);
  modport sink (input valid, input motor_sel, input feedback_type, input raw_value,
                output ready);
endinterface

/* rtl/motor_feedback_frame_parser.sv */
// Top level of the motor feedback frame parser.
// Depends on mffp_pkg and the channel interfaces in mffp_if.sv.
//
// The in_bus channel takes one received serial byte per beat. The parser looks
// for 9-byte frames: header, motor address, type, four data bytes (first one
// most significant), an XOR check byte and a tail. Each complete frame that
// passes the address, type, check and tail tests yields one beat on out_bus
// with the motor select, the type and the 32-bit data word; other bytes yield
// nothing. The five match registers are written through the APB-style cfg_
// port, at byte address 4 times the register index, and read back the same way.
// A byte is taken into an input register on acceptance and then parsed from
// there into the result register, which drives out_bus, so each result passes
// through both registers after its tail byte. One byte can be accepted every
// cycle; the only limit is the single result register. When the receiver stalls
// with a result pending, bytes that produce no result still flow, and only a
// second finished frame waits, which then holds back in_bus. A synchronous
// active-low reset clears the match registers to zero, empties both registers
// and restarts the header search.
module motor_feedback_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  mffp_in_if.sink                             in_bus,
  mffp_out_if.source                          out_bus,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mffp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [mffp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mffp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  mffp_pkg::byte_t header_r, tail_r, addr0_r, addr1_r, max_type_r;

  logic            stage_vld_r, stage_vld_nxt;
  mffp_pkg::byte_t stage_byte_r;

  mffp_pkg::phase_t phase_r, phase_nxt;
  mffp_pkg::count_t data_cnt_r, data_cnt_nxt;
  mffp_pkg::byte_t  frame_addr_r, frame_addr_nxt;
  mffp_pkg::byte_t  frame_type_r, frame_type_nxt;
  mffp_pkg::word_t  data_word_r, data_word_nxt;
  mffp_pkg::byte_t  xor_r, xor_nxt;
  mffp_pkg::byte_t  check_r, check_nxt;

  logic            out_vld_r, out_vld_nxt;
  logic            out_sel_r, out_sel_nxt;
  mffp_pkg::byte_t out_type_r, out_type_nxt;
  mffp_pkg::word_t out_value_r, out_value_nxt;

  logic       produce;
  logic       advance;
  logic       in_take;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r   <= '0;
      tail_r     <= '0;
      addr0_r    <= '0;
      addr1_r    <= '0;
      max_type_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mffp_pkg::REG_HEADER:   header_r   <= cfg_pwdata[7:0];
        mffp_pkg::REG_TAIL:     tail_r     <= cfg_pwdata[7:0];
        mffp_pkg::REG_ADDR0:    addr0_r    <= cfg_pwdata[7:0];
        mffp_pkg::REG_ADDR1:    addr1_r    <= cfg_pwdata[7:0];
        mffp_pkg::REG_MAX_TYPE: max_type_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mffp_pkg::REG_HEADER:   cfg_prdata = {24'd0, header_r};
      mffp_pkg::REG_TAIL:     cfg_prdata = {24'd0, tail_r};
      mffp_pkg::REG_ADDR0:    cfg_prdata = {24'd0, addr0_r};
      mffp_pkg::REG_ADDR1:    cfg_prdata = {24'd0, addr1_r};
      mffp_pkg::REG_MAX_TYPE: cfg_prdata = {24'd0, max_type_r};
      default:                cfg_prdata = '0;
    endcase
  end

  assign produce = stage_vld_r && (phase_r == mffp_pkg::PH_TAIL) &&
                   (stage_byte_r == tail_r) && (xor_r == check_r);
  assign advance = stage_vld_r && (!produce || !out_vld_r || out_bus.ready);
  assign in_bus.ready = !stage_vld_r || advance;
  assign in_take = in_bus.valid && in_bus.ready;

  always_comb begin
    stage_vld_nxt  = stage_vld_r;
    phase_nxt      = phase_r;
    data_cnt_nxt   = data_cnt_r;
    frame_addr_nxt = frame_addr_r;
    frame_type_nxt = frame_type_r;
    data_word_nxt  = data_word_r;
    xor_nxt        = xor_r;
    check_nxt      = check_r;
    out_vld_nxt    = out_vld_r;
    out_sel_nxt    = out_sel_r;
    out_type_nxt   = out_type_r;
    out_value_nxt  = out_value_r;

    if (in_take) begin
      stage_vld_nxt = 1'b1;
    end else if (advance) begin
      stage_vld_nxt = 1'b0;
    end

    if (out_vld_r && out_bus.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (advance) begin
      case (phase_r)
        mffp_pkg::PH_HEADER: begin
          if (stage_byte_r == header_r) begin
            xor_nxt       = stage_byte_r;
            data_word_nxt = '0;
            data_cnt_nxt  = '0;
            phase_nxt     = mffp_pkg::PH_ADDR;
          end
        end
        mffp_pkg::PH_ADDR: begin
          if (stage_byte_r == addr0_r || stage_byte_r == addr1_r) begin
            frame_addr_nxt = stage_byte_r;
            xor_nxt        = xor_r ^ stage_byte_r;
            phase_nxt      = mffp_pkg::PH_TYPE;
          end else begin
            phase_nxt    = mffp_pkg::PH_HEADER;
            data_cnt_nxt = '0;
          end
        end
        mffp_pkg::PH_TYPE: begin
          if (stage_byte_r <= max_type_r) begin
            frame_type_nxt = stage_byte_r;
            xor_nxt        = xor_r ^ stage_byte_r;
            phase_nxt      = mffp_pkg::PH_DATA;
          end else begin
            phase_nxt    = mffp_pkg::PH_HEADER;
            data_cnt_nxt = '0;
          end
        end
        mffp_pkg::PH_DATA: begin
          data_word_nxt = {data_word_r[23:0], stage_byte_r};
          xor_nxt       = xor_r ^ stage_byte_r;
          data_cnt_nxt  = data_cnt_r + 3'd1;
          if (data_cnt_nxt >= mffp_pkg::DATA_BYTES) begin
            phase_nxt = mffp_pkg::PH_CHECK;
          end
        end
        mffp_pkg::PH_CHECK: begin
          check_nxt = stage_byte_r;
          phase_nxt = mffp_pkg::PH_TAIL;
        end
        mffp_pkg::PH_TAIL: begin
          if (produce) begin
            out_vld_nxt   = 1'b1;
            out_sel_nxt   = (frame_addr_r != addr0_r);
            out_type_nxt  = frame_type_r;
            out_value_nxt = data_word_r;
          end
          phase_nxt    = mffp_pkg::PH_HEADER;
          data_cnt_nxt = '0;
        end
        default: begin
          phase_nxt    = mffp_pkg::PH_HEADER;
          data_cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      phase_r     <= mffp_pkg::PH_HEADER;
      data_cnt_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      phase_r     <= phase_nxt;
      data_cnt_r  <= data_cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_bus.rx_byte;
    end
    frame_addr_r <= frame_addr_nxt;
    frame_type_r <= frame_type_nxt;
    data_word_r  <= data_word_nxt;
    xor_r        <= xor_nxt;
    check_r      <= check_nxt;
    out_sel_r    <= out_sel_nxt;
    out_type_r   <= out_type_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.motor_sel     = out_sel_r;
  assign out_bus.feedback_type = out_type_r;
  assign out_bus.raw_value     = out_value_r;

  // A new result can only come from a tail byte that was parsed in the cycle before.
  a_result_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(phase_r) == mffp_pkg::PH_TAIL) && $past(advance))
    else $error("result raised without a parsed tail byte");

  // The data byte count never runs past the frame's data field.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    data_cnt_r <= mffp_pkg::DATA_BYTES)
    else $error("data byte count out of range");

  // The fourth data byte always moves the parser to the check byte.
  a_data_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == mffp_pkg::PH_DATA && data_cnt_r == 3'd3)
      |=> phase_r == mffp_pkg::PH_CHECK)
    else $error("data field did not end after four bytes");

  // A byte held in the input register is never dropped or overwritten.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_vld_r && !advance) |=> stage_vld_r && $stable(stage_byte_r))
    else $error("pending input byte lost");

endmodule

/* bench/tb_motor_feedback_frame_parser.sv */
// Testbench for motor_feedback_frame_parser: directed and random byte streams under
// several match register settings, checked beat by beat against a frame predictor.
// Depends on mffp_pkg, the channel interfaces in mffp_if.sv and the parser RTL.
module tb_motor_feedback_frame_parser;

  typedef struct packed {
    logic            motor_sel;
    mffp_pkg::byte_t feedback_type;
    mffp_pkg::word_t raw_value;
  } frame_result_t;

  typedef enum int {FLAW_NONE, FLAW_ADDR, FLAW_TYPE, FLAW_CHECK, FLAW_TAIL, FLAW_CUT} flaw_t;

  localparam int CYCLE_LIMIT = 200000;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [mffp_pkg::CFG_ADDR_W-1:0]     cfg_paddr;
  logic [mffp_pkg::CFG_DATA_W-1:0]     cfg_pwdata;
  logic [mffp_pkg::CFG_DATA_W-1:0]     cfg_prdata;
  logic                                cfg_pready;

  mffp_in_if  in_bus ();
  mffp_out_if out_bus ();

  motor_feedback_frame_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mffp_pkg::byte_t  match_header;
  mffp_pkg::byte_t  match_tail;
  mffp_pkg::byte_t  match_addr0;
  mffp_pkg::byte_t  match_addr1;
  mffp_pkg::byte_t  match_max_type;

  mffp_pkg::phase_t scan_phase;
  mffp_pkg::count_t data_bytes_seen;
  mffp_pkg::byte_t  frame_addr_q;
  mffp_pkg::byte_t  frame_type_q;
  mffp_pkg::word_t  data_acc;
  mffp_pkg::byte_t  xor_sum;
  mffp_pkg::byte_t  check_byte;

  frame_result_t    frames_due[$];
  frame_result_t    oldest_frame;
  mffp_pkg::byte_t  byte_queue[$];
  int               bytes_queued   = 0;
  int               bytes_accepted = 0;
  int               src_gap        = 0;
  int               sink_stall     = 0;
  int               idle_pct       = 15;
  int               error_count    = 0;
  int               cycle_count    = 0;

  always #10 clk = ~clk;

  function automatic void track_frame_byte(input mffp_pkg::byte_t b);
    frame_result_t r;
    case (scan_phase)
      mffp_pkg::PH_HEADER: begin
        if (b == match_header) begin
          xor_sum         = b;
          data_acc        = '0;
          data_bytes_seen = '0;
          scan_phase      = mffp_pkg::PH_ADDR;
        end
      end
      mffp_pkg::PH_ADDR: begin
        if (b == match_addr0 || b == match_addr1) begin
          frame_addr_q = b;
          xor_sum      = xor_sum ^ b;
          scan_phase   = mffp_pkg::PH_TYPE;
        end else begin
          scan_phase      = mffp_pkg::PH_HEADER;
          data_bytes_seen = '0;
        end
      end
      mffp_pkg::PH_TYPE: begin
        if (b <= match_max_type) begin
          frame_type_q = b;
          xor_sum      = xor_sum ^ b;
          scan_phase   = mffp_pkg::PH_DATA;
        end else begin
          scan_phase      = mffp_pkg::PH_HEADER;
          data_bytes_seen = '0;
        end
      end
      mffp_pkg::PH_DATA: begin
        data_acc        = {data_acc[23:0], b};
        xor_sum         = xor_sum ^ b;
        data_bytes_seen = data_bytes_seen + 3'd1;
        if (data_bytes_seen >= mffp_pkg::DATA_BYTES) begin
          scan_phase = mffp_pkg::PH_CHECK;
        end
      end
      mffp_pkg::PH_CHECK: begin
        check_byte = b;
        scan_phase = mffp_pkg::PH_TAIL;
      end
      mffp_pkg::PH_TAIL: begin
        if (b == match_tail && xor_sum == check_byte) begin
          r.motor_sel     = (frame_addr_q == match_addr0) ? 1'b0 : 1'b1;
          r.feedback_type = frame_type_q;
          r.raw_value     = data_acc;
          frames_due.push_back(r);
        end
        scan_phase      = mffp_pkg::PH_HEADER;
        data_bytes_seen = '0;
      end
      default: begin
        scan_phase      = mffp_pkg::PH_HEADER;
        data_bytes_seen = '0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.rx_byte <= '0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_frame_byte(in_bus.rx_byte);
        bytes_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          in_bus.valid <= 1'b0;
          src_gap--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_bus.valid <= 1'b0;
          src_gap = $urandom_range(0, 11);
        end else if (byte_queue.size() != 0) begin
          in_bus.valid   <= 1'b1;
          in_bus.rx_byte <= byte_queue.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (frames_due.size() == 0) begin
          $error("result beat with no frame expected: motor_sel %0d type %0d value %h",
                 out_bus.motor_sel, out_bus.feedback_type, out_bus.raw_value);
          error_count++;
        end else begin
          oldest_frame = frames_due.pop_front();
          if (out_bus.motor_sel !== oldest_frame.motor_sel) begin
            $error("motor_sel: expected %0d, actual %0d",
                   oldest_frame.motor_sel, out_bus.motor_sel);
            error_count++;
          end
          if (out_bus.feedback_type !== oldest_frame.feedback_type) begin
            $error("feedback_type: expected %0d, actual %0d",
                   oldest_frame.feedback_type, out_bus.feedback_type);
            error_count++;
          end
          if (out_bus.raw_value !== oldest_frame.raw_value) begin
            $error("raw_value: expected %h, actual %h",
                   oldest_frame.raw_value, out_bus.raw_value);
            error_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        out_bus.ready <= 1'b0;
        sink_stall--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_bus.ready <= 1'b0;
        sink_stall = $urandom_range(0, 11);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("motor_feedback_frame_parser test failed");
      $finish;
    end
  end

  task automatic send_byte(input mffp_pkg::byte_t b);
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input mffp_pkg::byte_t addr, input mffp_pkg::byte_t ftype,
                             input mffp_pkg::word_t data, input flaw_t flaw);
    mffp_pkg::byte_t frame_bytes [9];
    mffp_pkg::byte_t sum;
    int              keep;
    frame_bytes[0] = match_header;
    frame_bytes[1] = addr;
    frame_bytes[2] = ftype;
    frame_bytes[3] = data[31:24];
    frame_bytes[4] = data[23:16];
    frame_bytes[5] = data[15:8];
    frame_bytes[6] = data[7:0];
    if (flaw == FLAW_ADDR) begin
      do begin
        frame_bytes[1] = 8'($urandom_range(0, 255));
      end while (frame_bytes[1] == match_addr0 || frame_bytes[1] == match_addr1);
    end
    if (flaw == FLAW_TYPE) begin
      if (match_max_type == 8'hFF) begin
        flaw = FLAW_CHECK;
      end else begin
        frame_bytes[2] = 8'($urandom_range(int'(match_max_type) + 1, 255));
      end
    end
    sum = '0;
    for (int i = 0; i < 7; i++) begin
      sum = sum ^ frame_bytes[i];
    end
    frame_bytes[7] = sum;
    frame_bytes[8] = match_tail;
    if (flaw == FLAW_CHECK) begin
      frame_bytes[7] = sum ^ 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_TAIL) begin
      frame_bytes[8] = match_tail ^ 8'($urandom_range(1, 255));
    end
    keep = (flaw == FLAW_CUT) ? $urandom_range(1, 8) : 9;
    for (int i = 0; i < keep; i++) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  task automatic queue_random_frames(input int count);
    flaw_t flaw;
    int    roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        flaw = FLAW_NONE;
      end else if (roll < 78) begin
        flaw = FLAW_ADDR;
      end else if (roll < 84) begin
        flaw = FLAW_TYPE;
      end else if (roll < 90) begin
        flaw = FLAW_CHECK;
      end else if (roll < 95) begin
        flaw = FLAW_TAIL;
      end else begin
        flaw = FLAW_CUT;
      end
      queue_frame($urandom_range(0, 1) ? match_addr1 : match_addr0,
                  8'($urandom_range(0, match_max_type)), $urandom(), flaw);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_for_drain();
    while (bytes_accepted != bytes_queued || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic program_match_reg(input logic [2:0] idx, input mffp_pkg::byte_t value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'd0, value}) begin
      $error("register %0d readback: expected %h, actual %h", idx, value, cfg_prdata);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      mffp_pkg::REG_HEADER:   match_header   = value;
      mffp_pkg::REG_TAIL:     match_tail     = value;
      mffp_pkg::REG_ADDR0:    match_addr0    = value;
      mffp_pkg::REG_ADDR1:    match_addr1    = value;
      mffp_pkg::REG_MAX_TYPE: match_max_type = value;
      default: ;
    endcase
  endtask

  task automatic apply_match_set(input mffp_pkg::byte_t header, input mffp_pkg::byte_t tail,
                                 input mffp_pkg::byte_t addr0, input mffp_pkg::byte_t addr1,
                                 input mffp_pkg::byte_t max_type);
    program_match_reg(mffp_pkg::REG_HEADER, header);
    program_match_reg(mffp_pkg::REG_TAIL, tail);
    program_match_reg(mffp_pkg::REG_ADDR0, addr0);
    program_match_reg(mffp_pkg::REG_ADDR1, addr1);
    program_match_reg(mffp_pkg::REG_MAX_TYPE, max_type);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.rx_byte  = '0;
    out_bus.ready   = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    match_header    = '0;
    match_tail      = '0;
    match_addr0     = '0;
    match_addr1     = '0;
    match_max_type  = '0;
    scan_phase      = mffp_pkg::PH_HEADER;
    data_bytes_seen = '0;
    frame_addr_q    = '0;
    frame_type_q    = '0;
    data_acc        = '0;
    xor_sum         = '0;
    check_byte      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    queue_random_frames(10);
    wait_for_drain();

    apply_match_set(8'hA5, 8'h5A, 8'h01, 8'h02, 8'h07);
    queue_frame(match_addr1, match_max_type, 32'hFFFF_FFFF, FLAW_NONE);
    send_byte(match_header);
    send_byte(match_header);
    queue_frame(match_addr0, 8'h00, 32'h0000_0000, FLAW_NONE);
    send_byte(match_header);
    send_byte(match_addr0);
    send_byte(match_max_type + 8'd1);
    queue_random_frames(20);
    wait_for_drain();

    idle_pct = 30;
    apply_match_set(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    queue_random_frames(15);
    wait_for_drain();

    idle_pct = 5;
    apply_match_set(8'h3C, 8'hC3, 8'h11, 8'h11, 8'h00);
    queue_random_frames(15);
    wait_for_drain();

    idle_pct = 15;
    apply_match_set(8'h7E, 8'h7E, 8'h80, 8'h7F, 8'h80);
    queue_random_frames(10);
    wait_for_drain();
    queue_random_frames(10);
    wait_for_drain();

    idle_pct = 0;
    apply_match_set(8'h55, 8'hAA, 8'h00, 8'hFF, 8'h0F);
    queue_random_frames(20);
    wait_for_drain();
    repeat (4) @(posedge clk);

    if (error_count == 0 && frames_due.size() == 0) begin
      $display("motor_feedback_frame_parser test passed");
    end else begin
      $display("motor_feedback_frame_parser test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mffp_pkg.sv
rtl/mffp_if.sv
rtl/motor_feedback_frame_parser.sv
bench/tb_motor_feedback_frame_parser.sv
